@@ rtl/core/decimating_fir_filter_assert.svh @@
// Assertion macros used by the checker module.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef DECIMATING_FIR_FILTER_ASSERT_SVH
`define DECIMATING_FIR_FILTER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define DFIR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfir check failed");

// The consequent is written with its own delay, counted from the antecedent.
`define DFIR_ASSERT_SEQ(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("dfir check failed");

`endif

@@ rtl/core/dfir_pkg.sv @@
`default_nettype none
package dfir_pkg;

	localparam int unsigned MAX_DECIM_D   = 16;
	localparam int unsigned MAX_TAPS_D    = 127;
	localparam int unsigned SAMPLE_BITS_D = 24;
	localparam int unsigned COEF_BITS_D   = 18;

	localparam int unsigned FUNC_BITS = 2;
	localparam int unsigned CIDX_BITS = 7;
	localparam int unsigned CFG_BITS  = 5;
	// Tap count is eight taps per decimation step plus one, capped at MAX_TAPS.
	localparam int unsigned TAP_SHIFT = 3;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_COEF  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic acc_clear;
		logic issue;
		logic hist_ok;
		logic round_load;
	} mac_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/dfir_ram.sv @@
`default_nettype none
module dfir_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/dfir_ctrl.sv @@
`default_nettype none
module dfir_ctrl #(
	parameter int unsigned MAX_DECIM   = dfir_pkg::MAX_DECIM_D,
	parameter int unsigned MAX_TAPS    = dfir_pkg::MAX_TAPS_D,
	parameter int unsigned SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_D,
	localparam int unsigned TAP_AW = $clog2(MAX_TAPS)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dfir_pkg::CFG_BITS-1:0]  cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [dfir_pkg::FUNC_BITS-1:0] func,
	input  wire logic [SAMPLE_BITS-1:0]         sample,
	input  wire logic [dfir_pkg::CIDX_BITS-1:0] coef_index,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [SAMPLE_BITS-1:0]         filtered,
	output logic                                hist_we,
	output logic      [TAP_AW-1:0]              hist_waddr,
	output logic      [TAP_AW-1:0]              hist_raddr,
	output logic                                coef_we,
	output logic      [TAP_AW-1:0]              coef_waddr,
	output logic      [TAP_AW-1:0]              coef_raddr,
	output dfir_pkg::mac_ctl_t                  mac_ctl,
	input  wire logic                           mac_busy,
	input  wire logic [SAMPLE_BITS-1:0]         mac_result
);

	localparam int unsigned TAP_CW = $clog2(MAX_TAPS + 1);
	localparam int unsigned DEC_W  = $clog2(MAX_DECIM + 1);
	localparam int unsigned NT_W   = (DEC_W + dfir_pkg::TAP_SHIFT + 1 > TAP_CW) ?
		DEC_W + dfir_pkg::TAP_SHIFT + 1 : TAP_CW;
	localparam int unsigned CX_W   = DEC_W + dfir_pkg::CFG_BITS;
	localparam int unsigned CI_W   = TAP_CW + dfir_pkg::CIDX_BITS;

	function automatic logic [TAP_CW-1:0] taps_for(input logic [DEC_W-1:0] d);
		logic [NT_W-1:0] n;
		n = NT_W'({d, {dfir_pkg::TAP_SHIFT{1'b0}}}) + NT_W'(1);
		if (n > NT_W'(MAX_TAPS)) begin
			n = NT_W'(MAX_TAPS);
		end
		if (!n[0]) begin
			n = n - NT_W'(1);
		end
		return TAP_CW'(n);
	endfunction

	dfir_pkg::state_t state_q, state_d;

	logic [DEC_W-1:0]       dec_q;
	logic [TAP_CW-1:0]      ntaps_q;
	logic [TAP_AW-1:0]      wp_q;
	logic [DEC_W-1:0]       phase_q;
	logic [MAX_TAPS-1:0]    hvalid_q;
	logic [TAP_AW-1:0]      cnt_q;
	logic [TAP_AW-1:0]      idx_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] filtered_q;
	logic [SAMPLE_BITS-1:0] pass_sample_q;

	logic [CX_W-1:0]        cfg_ext;
	logic [DEC_W-1:0]       dec_new;
	logic [CI_W-1:0]        ci_ext;
	logic                   accept;
	logic                   is_pass;
	logic [TAP_AW-1:0]      last;
	logic [TAP_AW-1:0]      wp_eff;
	logic [TAP_AW-1:0]      wp_inc;
	logic [DEC_W-1:0]       phase_inc;
	logic                   fire;
	logic                   do_clear;
	logic                   do_push;
	logic                   out_free;
	logic                   load_out;

	always_comb begin
		cfg_ext = {{DEC_W{1'b0}}, cfg_data};
		if (cfg_ext == '0) begin
			dec_new = DEC_W'(1);
		end else if (cfg_ext > CX_W'(MAX_DECIM)) begin
			dec_new = DEC_W'(MAX_DECIM);
		end else begin
			dec_new = DEC_W'(cfg_ext);
		end
	end

	assign ci_ext    = {{TAP_CW{1'b0}}, coef_index};
	assign accept    = in_valid && in_ready;
	assign is_pass   = (dec_q == DEC_W'(1));
	assign last      = TAP_AW'(ntaps_q - TAP_CW'(1));
	// The position always stays inside the window; the wrap only guards it.
	assign wp_eff    = (TAP_CW'(wp_q) >= ntaps_q) ? '0 : wp_q;
	assign wp_inc    = (wp_eff == last) ? '0 : wp_eff + TAP_AW'(1);
	assign phase_inc = phase_q + DEC_W'(1);
	assign fire      = (phase_inc >= dec_q);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == dfir_pkg::ST_IDLE);
		hist_we  = 1'b0;
		coef_we  = 1'b0;
		do_clear = cfg_we;
		do_push  = 1'b0;
		load_out = 1'b0;
		mac_ctl  = '0;
		case (state_q)
			dfir_pkg::ST_IDLE: begin
				if (accept) begin
					case (func)
						dfir_pkg::FUNC_PUSH: begin
							if (is_pass) begin
								state_d = dfir_pkg::ST_PASS;
							end else begin
								hist_we = 1'b1;
								do_push = 1'b1;
								if (fire) begin
									mac_ctl.acc_clear = 1'b1;
									state_d = dfir_pkg::ST_MAC;
								end
							end
						end
						dfir_pkg::FUNC_COEF: begin
							coef_we = (ci_ext < CI_W'(MAX_TAPS));
						end
						dfir_pkg::FUNC_CLEAR: begin
							do_clear = 1'b1;
						end
						default: ;
					endcase
				end
			end
			dfir_pkg::ST_PASS: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = dfir_pkg::ST_IDLE;
				end
			end
			dfir_pkg::ST_MAC: begin
				mac_ctl.issue   = 1'b1;
				mac_ctl.hist_ok = hvalid_q[idx_q];
				if (cnt_q == last) begin
					state_d = dfir_pkg::ST_DRAIN;
				end
			end
			dfir_pkg::ST_DRAIN: begin
				if (!mac_busy) begin
					mac_ctl.round_load = 1'b1;
					state_d = dfir_pkg::ST_EMIT;
				end
			end
			dfir_pkg::ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = dfir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dfir_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfir_pkg::ST_IDLE;
			dec_q       <= DEC_W'(1);
			ntaps_q     <= taps_for(DEC_W'(1));
			wp_q        <= '0;
			phase_q     <= '0;
			hvalid_q    <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				dec_q   <= dec_new;
				ntaps_q <= taps_for(dec_new);
			end
			// A history entry whose valid bit is low reads as zero.
			if (do_clear) begin
				wp_q     <= '0;
				phase_q  <= '0;
				hvalid_q <= '0;
			end else if (do_push) begin
				hvalid_q[wp_eff] <= 1'b1;
				wp_q             <= wp_inc;
				phase_q          <= fire ? '0 : phase_inc;
			end
			// The walk starts at the oldest entry, which is the next write slot.
			if (do_push && fire) begin
				cnt_q <= '0;
				idx_q <= wp_inc;
			end else if (mac_ctl.issue) begin
				cnt_q <= cnt_q + TAP_AW'(1);
				idx_q <= (idx_q == last) ? '0 : idx_q + TAP_AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pass_sample_q <= sample;
		end
		if (load_out) begin
			filtered_q <= (state_q == dfir_pkg::ST_PASS) ? pass_sample_q : mac_result;
		end
	end

	assign hist_waddr = wp_eff;
	assign hist_raddr = idx_q;
	assign coef_waddr = TAP_AW'(ci_ext);
	assign coef_raddr = cnt_q;
	assign out_valid  = out_valid_q;
	assign filtered   = filtered_q;

endmodule
`default_nettype wire

@@ rtl/core/dfir_mac.sv @@
`default_nettype none
module dfir_mac #(
	parameter int unsigned MAX_TAPS    = dfir_pkg::MAX_TAPS_D,
	parameter int unsigned SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_D,
	parameter int unsigned COEF_BITS   = dfir_pkg::COEF_BITS_D
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dfir_pkg::mac_ctl_t     ctl,
	input  wire logic [SAMPLE_BITS-1:0] hist_rdata,
	input  wire logic [COEF_BITS-1:0]   coef_rdata,
	output logic                        busy,
	output logic      [SAMPLE_BITS-1:0] result
);

	localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_TAPS);
	localparam int unsigned RND_W  = ACC_W + 1;
	localparam int unsigned SH     = COEF_BITS - 1;
	localparam int unsigned Q_W    = RND_W - SH;
	localparam int unsigned UP_W   = Q_W - SAMPLE_BITS + 1;
	localparam logic [RND_W-1:0] HALF = RND_W'(64'd1 << (COEF_BITS - 2));

	logic                     v_s1;
	logic                     hok_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic        [ACC_W-1:0]  acc_q;
	logic        [RND_W-1:0]  rnd_q;
	logic        [Q_W-1:0]    q;
	logic        [UP_W-1:0]   upper;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			hok_s1 <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1   <= ctl.issue;
			hok_s1 <= ctl.hist_ok;
			v_s2   <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= hok_s1 ? $signed(hist_rdata) * $signed(coef_rdata)
				: $signed(PROD_W'(0));
		end
		if (ctl.acc_clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
		if (ctl.round_load) begin
			rnd_q <= {acc_q[ACC_W-1], acc_q} + HALF;
		end
	end

	// Dropping the low bits is the arithmetic shift; the top bits decide saturation.
	assign q     = rnd_q[RND_W-1:SH];
	assign upper = q[Q_W-1:SAMPLE_BITS-1];

	always_comb begin
		if (upper == '0 || upper == '1) begin
			result = q[SAMPLE_BITS-1:0];
		end else if (q[Q_W-1]) begin
			result = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end
	end

	assign busy = v_s1 || v_s2;

endmodule
`default_nettype wire

@@ rtl/core/decimating_fir_filter.sv @@
// Channel   Direction  Handshake              Word
// config    in         cfg_we                 cfg_data (decimation factor)
// input     in         in_valid / in_ready    func, sample, coef_index, coef_value
// output    out        out_valid / out_ready  filtered
//
// Coefficient, clear and non-output sample words leave the block idle and ready.
// A pass-through sample is held in a sample register until the output register is free.
// For an output sample, one multiply-accumulate walks
// the history and coefficient RAMs one tap per cycle through their read ports.
// Reset clears the history valid bits at once; there is no clearing pass.
// A finished word waits in the output register; input is taken meanwhile
// until the next result needs that register.
`default_nettype none
module decimating_fir_filter #(
	parameter int unsigned MAX_DECIM   = dfir_pkg::MAX_DECIM_D,
	parameter int unsigned MAX_TAPS    = dfir_pkg::MAX_TAPS_D,
	parameter int unsigned SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_D,
	parameter int unsigned COEF_BITS   = dfir_pkg::COEF_BITS_D
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dfir_pkg::CFG_BITS-1:0]  cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [dfir_pkg::FUNC_BITS-1:0] func,
	input  wire logic [SAMPLE_BITS-1:0]         sample,
	input  wire logic [dfir_pkg::CIDX_BITS-1:0] coef_index,
	input  wire logic [COEF_BITS-1:0]           coef_value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [SAMPLE_BITS-1:0]         filtered
);

	localparam int unsigned TAP_AW = $clog2(MAX_TAPS);

	logic                   hist_we;
	logic [TAP_AW-1:0]      hist_waddr;
	logic [TAP_AW-1:0]      hist_raddr;
	logic [SAMPLE_BITS-1:0] hist_rdata;
	logic                   coef_we;
	logic [TAP_AW-1:0]      coef_waddr;
	logic [TAP_AW-1:0]      coef_raddr;
	logic [COEF_BITS-1:0]   coef_rdata;
	dfir_pkg::mac_ctl_t     mac_ctl;
	logic                   mac_busy;
	logic [SAMPLE_BITS-1:0] mac_result;

	dfir_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_TAPS)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(sample),
		.re   (mac_ctl.issue),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	dfir_ram #(
		.WIDTH(COEF_BITS),
		.DEPTH(MAX_TAPS)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(coef_value),
		.re   (mac_ctl.issue),
		.raddr(coef_raddr),
		.rdata(coef_rdata)
	);

	dfir_ctrl #(
		.MAX_DECIM  (MAX_DECIM),
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.sample    (sample),
		.coef_index(coef_index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.hist_we   (hist_we),
		.hist_waddr(hist_waddr),
		.hist_raddr(hist_raddr),
		.coef_we   (coef_we),
		.coef_waddr(coef_waddr),
		.coef_raddr(coef_raddr),
		.mac_ctl   (mac_ctl),
		.mac_busy  (mac_busy),
		.mac_result(mac_result)
	);

	dfir_mac #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.hist_rdata(hist_rdata),
		.coef_rdata(coef_rdata),
		.busy      (mac_busy),
		.result    (mac_result)
	);

endmodule
`default_nettype wire

@@ rtl/core/dfir_checker.sv @@
`default_nettype none
`include "decimating_fir_filter_assert.svh"
module dfir_checker #(
	parameter int unsigned SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_D
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_we,
	input wire logic [dfir_pkg::CFG_BITS-1:0]  cfg_data,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic [dfir_pkg::FUNC_BITS-1:0] func,
	input wire logic [SAMPLE_BITS-1:0]         sample,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [SAMPLE_BITS-1:0]         filtered
);

	// Tracks whether the block is in pass-through (decimation factor of one).
	logic pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b1;
		end else if (cfg_we) begin
			pass_q <= (cfg_data <= dfir_pkg::CFG_BITS'(1));
		end
	end

	`DFIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(filtered))

	`DFIR_ASSERT_NEXT(a_no_early_word, in_valid && in_ready && !out_valid, !out_valid)

	`DFIR_ASSERT_SEQ(a_pass_through,
		in_valid && in_ready && func == dfir_pkg::FUNC_PUSH && pass_q && !out_valid,
		##2 (out_valid && filtered == $past(sample, 2)))

endmodule

bind decimating_fir_filter dfir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dfir_checker (.*);
`default_nettype wire
